FILE: hdl/upta_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the UDP port table allocator.
package upta_pkg;

  localparam int PORT_W    = 16;
  localparam int OWNER_W   = 8;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam int PORT_COUNT   = 65536;
  localparam int SEARCH_LIMIT = 10000;
  localparam int CNT_W        = $clog2(SEARCH_LIMIT + 1);

  // Valid bits are stored 32 to a row so the reset sweep is short.
  localparam int ROW_BITS = 32;
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int VROWS    = PORT_COUNT / ROW_BITS;
  localparam int VROW_AW  = $clog2(VROWS);
  localparam int OWN_AW   = $clog2(PORT_COUNT);

  localparam logic [PORT_W-1:0] RANGE_BASE_RST = PORT_W'(50000);
  localparam logic [PORT_W-1:0] RANGE_END_RST  = PORT_W'(60000);

  localparam logic [MODE_W-1:0] MODE_CLAIM   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RELEASE = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = MODE_W'(2);

  localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_INUSE = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_MISS  = STATUS_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END  = CFG_IDX_W'(1);

  typedef struct packed {
    logic clr_step;
    logic load;
    logic finish_fixed;
    logic search_step;
  } upta_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic start_search;
    logic search_done;
    logic out_free;
  } upta_sts_t;

  function automatic logic port_in_table(input logic [PORT_W-1:0] p);
    return (32'(p) < PORT_COUNT);
  endfunction

  function automatic logic [PORT_W-1:0] probe_next(input logic [PORT_W-1:0] p,
                                                   input logic [PORT_W-1:0] b,
                                                   input logic [PORT_W-1:0] e);
    logic [PORT_W-1:0] n;
    n = p + PORT_W'(1);
    if (n >= e || n < b) begin
      n = b;
    end
    return n;
  endfunction

endpackage

FILE: hdl/upta_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result transfers.
interface upta_in_if;
  import upta_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PORT_W-1:0]   port;
  logic [OWNER_W-1:0]  owner;
  modport source(output valid, output mode, output port, output owner, input ready);
  modport sink(input valid, input mode, input port, input owner, output ready);
endinterface

interface upta_out_if;
  import upta_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PORT_W-1:0]   result_port;
  logic [OWNER_W-1:0]  found_owner;
  modport source(output valid, output status, output result_port, output found_owner,
                 input ready);
  modport sink(input valid, input status, input result_port, input found_owner,
               output ready);
endinterface

FILE: hdl/upta_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the port table allocator.
module upta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  upta_pkg::upta_sts_t sts_i,
  output upta_pkg::upta_cmd_t cmd_o
);
  import upta_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_FIXED  = 4'b0100,
    S_SEARCH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = sts_i.start_search ? S_SEARCH : S_FIXED;
        end
      end
      S_FIXED: begin
        if (sts_i.out_free) begin
          cmd_o.finish_fixed = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (sts_i.out_free) begin
          cmd_o.search_step = 1'b1;
          if (sts_i.search_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: hdl/upta_datapath.sv
`timescale 1ns / 1ps
// Port table memories, probe pipeline, config registers and result register.
module upta_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  upta_pkg::upta_cmd_t             cmd_i,
  output upta_pkg::upta_sts_t             sts_o,
  input  logic                            cfg_we,
  input  logic [upta_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [upta_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [upta_pkg::MODE_W-1:0]     in_mode,
  input  logic [upta_pkg::PORT_W-1:0]     in_port,
  input  logic [upta_pkg::OWNER_W-1:0]    in_owner,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [upta_pkg::STATUS_W-1:0]   out_status,
  output logic [upta_pkg::PORT_W-1:0]     out_result_port,
  output logic [upta_pkg::OWNER_W-1:0]    out_found_owner
);
  import upta_pkg::*;

  logic [ROW_BITS-1:0] vmem [VROWS];
  logic [OWNER_W-1:0]  omem [PORT_COUNT];

  logic [PORT_W-1:0]   base_r, end_r;
  logic [VROW_AW-1:0]  clr_row_r;
  logic [MODE_W-1:0]   mode_r;
  logic [PORT_W-1:0]   port_r;
  logic [OWNER_W-1:0]  owner_r;
  logic [PORT_W-1:0]   next_port_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                chk_vld_r;
  logic [PORT_W-1:0]   chk_port_r, chk_next_r;
  logic [ROW_BITS-1:0] vrow_q;
  logic [OWNER_W-1:0]  own_q;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PORT_W-1:0]   out_port_r;
  logic [OWNER_W-1:0]  out_owner_r;

  logic                in_tbl, cur_bit;
  logic [STATUS_W-1:0] f_status;
  logic [OWNER_W-1:0]  f_owner;
  logic                f_set, f_clr;
  logic                issue_ok, probe_in, found, exhausted, search_fin, finish_any;
  logic [PORT_W-1:0]   probe_nxt;
  logic                v_we, v_re, o_we;
  logic [VROW_AW-1:0]  v_waddr, v_raddr;
  logic [ROW_BITS-1:0] v_wdata;
  logic [OWN_AW-1:0]   o_waddr;

  // Fixed claim, release, lookup
  assign in_tbl  = port_in_table(port_r);
  assign cur_bit = vrow_q[port_r[BIT_W-1:0]];

  always_comb begin
    f_status = ST_INUSE;
    f_owner  = '0;
    f_set    = 1'b0;
    f_clr    = 1'b0;
    case (mode_r)
      MODE_CLAIM: begin
        if (in_tbl && !cur_bit) begin
          f_status = ST_OK;
          f_set    = 1'b1;
        end
      end
      MODE_RELEASE: begin
        f_status = ST_OK;
        f_clr    = in_tbl;
      end
      MODE_LOOKUP: begin
        if (in_tbl && cur_bit) begin
          f_status = ST_OK;
          f_owner  = own_q;
        end else begin
          f_status = ST_MISS;
        end
      end
      default: begin
        f_status = ST_INUSE;
      end
    endcase
  end

  // Ephemeral search: issue one probe per step, check the previous one
  assign issue_ok   = (cnt_r != CNT_W'(SEARCH_LIMIT));
  assign probe_in   = (next_port_r >= base_r) && (next_port_r < end_r) &&
                      port_in_table(next_port_r);
  assign probe_nxt  = probe_next(next_port_r, base_r, end_r);
  assign found      = chk_vld_r && !vrow_q[chk_port_r[BIT_W-1:0]];
  assign exhausted  = !issue_ok && !chk_vld_r;
  assign search_fin = cmd_i.search_step && (found || exhausted);
  assign finish_any = cmd_i.finish_fixed || search_fin;

  assign sts_o.clr_done     = (clr_row_r == VROW_AW'(VROWS - 1));
  assign sts_o.start_search = (in_mode == MODE_CLAIM) && (in_port == '0);
  assign sts_o.search_done  = found || exhausted;
  assign sts_o.out_free     = !out_valid_r || out_ready;

  // Memory port control
  always_comb begin
    v_we    = 1'b0;
    v_waddr = clr_row_r;
    v_wdata = '0;
    if (cmd_i.clr_step) begin
      v_we = 1'b1;
    end else if (cmd_i.finish_fixed && (f_set || f_clr)) begin
      v_we    = 1'b1;
      v_waddr = port_r[BIT_W +: VROW_AW];
      v_wdata = vrow_q;
      v_wdata[port_r[BIT_W-1:0]] = f_set;
    end else if (cmd_i.search_step && found) begin
      v_we    = 1'b1;
      v_waddr = chk_port_r[BIT_W +: VROW_AW];
      v_wdata = vrow_q;
      v_wdata[chk_port_r[BIT_W-1:0]] = 1'b1;
    end
  end

  assign v_re    = cmd_i.load || (cmd_i.search_step && issue_ok);
  assign v_raddr = cmd_i.load ? in_port[BIT_W +: VROW_AW] : next_port_r[BIT_W +: VROW_AW];
  assign o_we    = (cmd_i.finish_fixed && f_set) || (cmd_i.search_step && found);
  assign o_waddr = cmd_i.finish_fixed ? port_r[OWN_AW-1:0] : chk_port_r[OWN_AW-1:0];

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      vrow_q <= vmem[v_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      omem[o_waddr] <= owner_r;
    end
    if (cmd_i.load) begin
      own_q <= omem[in_port[OWN_AW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= RANGE_BASE_RST;
      end_r       <= RANGE_END_RST;
      clr_row_r   <= '0;
      next_port_r <= RANGE_BASE_RST;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RANGE_BASE: base_r <= cfg_wdata;
          CFG_RANGE_END:  end_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_row_r <= clr_row_r + VROW_AW'(1);
      end
      if (cmd_i.load) begin
        cnt_r     <= '0;
        chk_vld_r <= 1'b0;
      end else if (cmd_i.search_step) begin
        if (issue_ok) begin
          cnt_r     <= cnt_r + CNT_W'(1);
          chk_vld_r <= probe_in;
        end else begin
          chk_vld_r <= 1'b0;
        end
        if (found) begin
          next_port_r <= chk_next_r;
        end else if (issue_ok) begin
          next_port_r <= probe_nxt;
        end
      end
      if (finish_any) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mode_r  <= in_mode;
      port_r  <= in_port;
      owner_r <= in_owner;
    end
    if (cmd_i.search_step && issue_ok) begin
      chk_port_r <= next_port_r;
      chk_next_r <= probe_nxt;
    end
    if (cmd_i.finish_fixed) begin
      out_status_r <= f_status;
      out_port_r   <= port_r;
      out_owner_r  <= f_owner;
    end else if (search_fin) begin
      out_status_r <= found ? ST_OK : ST_INUSE;
      out_port_r   <= found ? chk_port_r : '0;
      out_owner_r  <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_port = out_port_r;
  assign out_found_owner = out_owner_r;

endmodule

FILE: hdl/udp_port_table_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the UDP port table allocator with next-fit ephemeral search.
//
//   channel  direction  handshake      payload
//   in_if    sink       valid/ready    mode, port, owner
//   out_if   source     valid/ready    status, result_port, found_owner
//   cfg_*    sink       cfg_we only    cfg_idx, cfg_wdata
//
// Claim of a given port, release and lookup read the table on load, then a claim or
// release read-modify-writes the valid row, and a claim writes the owner memory.
// Claim of port zero: a load, then one probe per cycle while the output is free, up to
// a free port or the limit; probes are pipelined through the valid-row read port.
// After reset all 2048 rows of the valid table are swept; no transfer is taken.
// A stalled output holds the final step of a fixed item and every probe of a search.
module udp_port_table_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  upta_in_if.sink                        in_if,
  upta_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [upta_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [upta_pkg::CFG_W-1:0]     cfg_wdata
);
  import upta_pkg::*;

  upta_cmd_t cmd;
  upta_sts_t sts;
  logic      in_ready;

  upta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  upta_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_if.mode),
    .in_port         (in_if.port),
    .in_owner        (in_if.owner),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_status      (out_if.status),
    .out_result_port (out_if.result_port),
    .out_found_owner (out_if.found_owner)
  );

  assign in_if.ready = in_ready;

endmodule
